// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: lbl");

// trig in a cycle requires cond in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed: lbl");

// trig in a cycle requires cond in the following cycle
`define ASSERT_NEXT(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed: lbl");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLIES(lbl, clk, rst, trig, cond)
`define ASSERT_NEXT(lbl, clk, rst, trig, cond)

`endif

`endif

// ===== rtl/orb_pkg.sv =====
package orb_pkg;

  localparam int ELEM_WIDTH = 32;
  localparam int CW         = 5;   // capacity and count
  localparam int OFF_W      = 4;

  localparam logic [CW-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    KIND_PUT       = 2'd0,
    KIND_GET       = 2'd1,
    KIND_PEEK_OLD  = 2'd2,
    KIND_PEEK_BACK = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_RANGE   = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                 kind;
    logic [ELEM_WIDTH-1:0] write_data;
    logic [OFF_W-1:0]      offset;
  } in_word_t;

  typedef struct packed {
    logic [ELEM_WIDTH-1:0] read_data;
    status_t               status;
    logic [CW-1:0]         count;
    logic                  is_full;
    logic                  is_empty;
  } out_word_t;

  // per-cell strobes decoded by the controller
  typedef struct packed {
    logic wr_sel;
    logic rd_sel;
  } cell_ctl_t;

endpackage

// ===== rtl/orb_cell.sv =====
module orb_cell (
  input  logic                           clk,
  input  orb_pkg::cell_ctl_t             ctl,
  input  logic [orb_pkg::ELEM_WIDTH-1:0] wr_data,
  input  logic [orb_pkg::ELEM_WIDTH-1:0] chain_in,
  output logic [orb_pkg::ELEM_WIDTH-1:0] chain_out
);

  logic [orb_pkg::ELEM_WIDTH-1:0] slot;
  logic [orb_pkg::ELEM_WIDTH-1:0] chain_q;

  // store on a put; insert own slot into the read chain when selected,
  // else pass the upstream word along
  always_ff @(posedge clk) begin
    if (ctl.wr_sel) begin
      slot <= wr_data;
    end
    chain_q <= ctl.rd_sel ? slot : chain_in;
  end

  assign chain_out = chain_q;

endmodule

// ===== rtl/overwrite_ring_buffer_unit.sv =====
// Channel   Dir  Handshake               Payload
// in        in   in_valid / in_stall     orb_pkg::in_word_t  (kind, write_data, offset)
// out       out  out_valid / out_stall   orb_pkg::out_word_t (read_data, status, count,
//                                                             is_full, is_empty)
// cfg       in   cfg_valid / cfg_ready   capacity (5 bits)
//
// A put, or any operation that ends in an error status, goes from accept to
//   S_DONE and back to idle; a get or a peek first passes through S_READ, where
//   the read chain carries the selected slot from its cell to the chain end.
// One operation is in work at a time; a finished word waits in the output
//   register while the next operation is accepted and worked on.
// Reset (rst, synchronous) empties the buffer and sets the capacity to 16
//   (or DEPTH if smaller); slot contents are not cleared.
// A stall on out holds the output word; the pending result then waits in the
//   result register and in_stall stays high until the output frees up.
`include "assert_macros.svh"

module overwrite_ring_buffer_unit #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  orb_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output orb_pkg::out_word_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [orb_pkg::CW-1:0]        cfg_data
);

  localparam int CW = orb_pkg::CW;
  localparam int PW = $clog2(DEPTH);      // slot pointer
  localparam int WW = $clog2(DEPTH + 1);  // chain wait counter

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Clamp a written capacity: zero acts as one, anything above DEPTH as DEPTH.
  function automatic logic [CW-1:0] clamp_cap(input logic [CW-1:0] c);
    logic [CW-1:0] r;
    if (c == '0) begin
      r = CW'(1);
    end else if (int'(c) > DEPTH) begin
      r = CW'(DEPTH);
    end else begin
      r = c;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  state_t          state;
  logic [CW-1:0]   cap_eff;   // effective capacity, already clamped
  logic [PW-1:0]   wp;        // next slot to write
  logic [PW-1:0]   rp;        // oldest element
  logic [CW-1:0]   cnt;       // stored elements
  logic [WW-1:0]   wait_cnt;

  // payload registers
  logic [PW-1:0]       rd_idx;
  orb_pkg::out_word_t  res;

  logic in_fire, cfg_fire, out_free;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || !out_stall;

  // ---------------------------------------------------------------------------
  // Operation decode, evaluated on the accepted word
  // ---------------------------------------------------------------------------
  logic [CW-1:0] wp_w, rp_w, wp_inc, rp_inc, wp_adv, rp_adv;
  logic [CW-1:0] back, idx_back;
  logic          is_full_now, is_empty_now;

  logic [PW-1:0]    wp_next, rp_next, rd_idx_next;
  logic [CW-1:0]    cnt_next;
  orb_pkg::status_t status_next;
  logic             need_read, put_we;

  assign wp_w   = CW'(wp);
  assign rp_w   = CW'(rp);
  assign wp_inc = wp_w + CW'(1);
  assign rp_inc = rp_w + CW'(1);
  // advance with wrap at the effective capacity
  assign wp_adv = (wp_inc >= cap_eff) ? '0 : wp_inc;
  assign rp_adv = (rp_inc >= cap_eff) ? '0 : rp_inc;

  assign is_full_now  = (cnt == cap_eff);
  assign is_empty_now = (cnt == '0);

  // slot that lies offset places back from the newest; wraps through the
  // effective capacity, modular arithmetic keeps the narrow sum correct
  assign back     = CW'(in_data.offset) + CW'(1);
  assign idx_back = (wp_w >= back) ? (wp_w - back) : (cap_eff + wp_w - back);

  always_comb begin
    wp_next     = wp;
    rp_next     = rp;
    cnt_next    = cnt;
    rd_idx_next = rp;
    status_next = orb_pkg::ST_OK;
    need_read   = 1'b0;
    put_we      = 1'b0;
    case (in_data.kind)
      orb_pkg::KIND_PUT: begin
        put_we  = 1'b1;
        wp_next = PW'(wp_adv);
        if (is_full_now) begin
          // drop the oldest to make room; count stays at capacity
          rp_next     = PW'(rp_adv);
          status_next = orb_pkg::ST_DROPPED;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      orb_pkg::KIND_GET: begin
        if (is_empty_now) begin
          status_next = orb_pkg::ST_EMPTY;
        end else begin
          rd_idx_next = rp;
          rp_next     = PW'(rp_adv);
          cnt_next    = cnt - CW'(1);
          need_read   = 1'b1;
        end
      end
      orb_pkg::KIND_PEEK_OLD: begin
        if (is_empty_now) begin
          status_next = orb_pkg::ST_EMPTY;
        end else begin
          rd_idx_next = rp;
          need_read   = 1'b1;
        end
      end
      orb_pkg::KIND_PEEK_BACK: begin
        if (is_empty_now) begin
          status_next = orb_pkg::ST_EMPTY;
        end else if (CW'(in_data.offset) >= cnt) begin
          status_next = orb_pkg::ST_RANGE;
        end else begin
          rd_idx_next = PW'(idx_back);
          need_read   = 1'b1;
        end
      end
      default: begin
        status_next = orb_pkg::ST_OK;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Cell chain: slot i lives in cell i; the read word ripples toward the end
  // ---------------------------------------------------------------------------
  logic [orb_pkg::ELEM_WIDTH-1:0] chain [DEPTH+1];

  assign chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    orb_pkg::cell_ctl_t ctl;
    assign ctl.wr_sel = in_fire && put_we && (wp == PW'(i));
    assign ctl.rd_sel = (rd_idx == PW'(i));

    orb_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .wr_data   (in_data.write_data),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Sequencer and pointers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap_eff   <= clamp_cap(orb_pkg::CAP_RESET);
      wp        <= '0;
      rp        <= '0;
      cnt       <= '0;
      wait_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      // a capacity write empties the buffer; slot contents stay
      if (cfg_fire) begin
        cap_eff <= clamp_cap(cfg_data);
        wp      <= '0;
        rp      <= '0;
        cnt     <= '0;
      end else if (in_fire) begin
        wp  <= wp_next;
        rp  <= rp_next;
        cnt <= cnt_next;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            wait_cnt <= '0;
            state    <= need_read ? S_READ : S_DONE;
          end
        end
        S_READ: begin
          // hold rd_idx until the selected slot reaches the chain end
          wait_cnt <= wait_cnt + WW'(1);
          if (wait_cnt == WW'(DEPTH)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result and output words
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_fire) begin
      rd_idx        <= rd_idx_next;
      res.read_data <= '0;
      res.status    <= status_next;
      res.count     <= cnt_next;
      res.is_full   <= (cnt_next == cap_eff);
      res.is_empty  <= (cnt_next == '0);
    end
    if (state == S_READ && wait_cnt == WW'(DEPTH)) begin
      res.read_data <= chain[DEPTH];
    end
    if (state == S_DONE && out_free) begin
      out_data <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_cnt_le_cap, clk, rst, cnt <= cap_eff)
  `ASSERT_ALWAYS(a_ptr_in_range, clk, rst, (CW'(wp) < cap_eff) && (CW'(rp) < cap_eff))
  `ASSERT_IMPLIES(a_out_flags, clk, rst, out_valid, !(out_data.is_full && out_data.is_empty))
  `ASSERT_NEXT(a_read_ends, clk, rst, (state == S_READ) && (wait_cnt == WW'(DEPTH)), state == S_DONE)

endmodule
